/* sv/dwe_pkg.sv */
// dwe_pkg: shared types and constants of the DCTCP window estimator.
// Used by the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package dwe_pkg;

  // Configuration register indexes
  typedef enum logic [3:0] {
    CFG_FLOW_BYTES     = 4'd0,
    CFG_SEGMENT_BYTES  = 4'd1,
    CFG_GAIN_SHIFT     = 4'd2,
    CFG_INITIAL_WINDOW = 4'd3
  } cfg_reg_e;

  // Register reset values
  localparam logic [31:0] FLOW_BYTES_RST     = 32'd0;
  localparam logic [15:0] SEGMENT_BYTES_RST  = 16'd1460;
  localparam logic [3:0]  GAIN_SHIFT_RST     = 4'd4;
  localparam int unsigned INITIAL_WINDOW_RST = 10;

  // Q0.16 one and two, SACK byte count ceiling
  localparam logic [16:0] ALPHA_ONE = 17'd65536;
  localparam logic [17:0] ALPHA_TWO = 18'd131072;
  localparam logic [23:0] SACK_MAX  = 24'hFFFFFF;

  // History is counted this many entries per cycle
  localparam int unsigned CHUNK_W = 16;

  typedef struct packed {
    logic [31:0] ack_seq;
    logic        ecn_echo;
    logic [8:0]  sack_blocks;
  } ack_beat_t;

  typedef struct packed {
    logic        new_ack;
    logic [8:0]  window_out;
    logic [16:0] alpha_out;
    logic [31:0] send_seq_out;
    logic [23:0] sack_bytes;
    logic        flow_finished;
  } result_beat_t;

  typedef struct packed {
    logic [3:0]  index;
    logic [31:0] value;
  } cfg_beat_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;
    logic count_step;
    logic div_init;
    logic div_step;
    logic alpha_upd;
    logic mul_run;
    logic win_upd;
    logic out_load;
  } dwe_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_new;
    logic count_done;
    logic div_done;
  } dwe_stat_t;

endpackage

`default_nettype wire

/* sv/dwe_stream_if.sv */
// dwe_stream_if: valid/ready channel carrying one payload beat.
// Payload type is a parameter; beat types come from dwe_pkg.
`default_nettype none

interface dwe_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/dctcp_window_estimator_unit.sv */
// dctcp_window_estimator_unit: top level of the DCTCP window estimator.
// Depends on dwe_pkg, dwe_stream_if, dwe_ctrl and dwe_datapath.
//
// Usage:
//   ack_i  - one beat per acknowledgement (ack_seq, ecn_echo, sack_blocks).
//   res_o  - exactly one result beat per accepted ack, in order.
//   cfg_i  - register writes (index, value), always ready; write only while
//            idle. Writing initial_window also reloads the window at once.
// Sequence per ack:
//   Old or repeated ack: check, then result load. New ack: history counted
//   16 entries a cycle, 16-step restoring divide for the mark fraction,
//   alpha update, multiply and clamp, then result load. One ack in flight;
//   ack_i.ready is back right after the result loads, so the next ack is
//   accepted only once the previous result has been loaded.
// Reset: rst_ni clears history, alpha and sequence state, loads register
//   defaults and a window of 10 segments (clamped to MAX_WINDOW).
// Stall: the result waits in an output register; the next ack is accepted
//   while it waits, and that ack's result is held back until the first is taken.
`default_nettype none

module dctcp_window_estimator_unit #(
  parameter int unsigned MAX_WINDOW = 256
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dwe_stream_if.sink   ack_i,
  dwe_stream_if.source res_o,
  dwe_stream_if.sink   cfg_i
);

  dwe_pkg::dwe_cmd_t  cmd;
  dwe_pkg::dwe_stat_t stat;
  logic               ack_ready;
  logic               res_valid;
  logic               cfg_we;

  // configuration never back-pressures
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  assign ack_i.ready = ack_ready;
  assign res_o.valid = res_valid;

  dwe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ack_valid_i (ack_i.valid),
    .ack_ready_o (ack_ready),
    .res_valid_o (res_valid),
    .res_ready_i (res_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dwe_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .ack_data_i (ack_i.data),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_i.data),
    .res_data_o (res_o.data)
  );

endmodule

`default_nettype wire

/* sv/dwe_ctrl.sv */
// dwe_ctrl: sequencing state machine of the DCTCP window estimator.
// Depends on dwe_pkg (command and status structs).
`default_nettype none

module dwe_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              ack_valid_i,
  output logic                   ack_ready_o,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  input  wire dwe_pkg::dwe_stat_t stat_i,
  output dwe_pkg::dwe_cmd_t      cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_CHECK    = 9'b000000010,
    ST_COUNT    = 9'b000000100,
    ST_DIV_INIT = 9'b000001000,
    ST_DIV_STEP = 9'b000010000,
    ST_ALPHA    = 9'b000100000,
    ST_MUL      = 9'b001000000,
    ST_WIN      = 9'b010000000,
    ST_DONE     = 9'b100000000
  } dwe_state_e;

  dwe_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       ack_fire;

  assign ack_ready_o = (state_q == ST_IDLE);
  assign ack_fire    = ack_valid_i && ack_ready_o;
  assign res_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (ack_fire) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = stat_i.is_new ? ST_COUNT : ST_DONE;
      end
      ST_COUNT: begin
        cmd_o.count_step = 1'b1;
        if (stat_i.count_done) begin
          state_d = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) begin
          state_d = ST_ALPHA;
        end
      end
      ST_ALPHA: begin
        cmd_o.alpha_upd = 1'b1;
        state_d         = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_run = 1'b1;
        state_d       = ST_WIN;
      end
      ST_WIN: begin
        cmd_o.win_upd = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to drain
        if (!out_valid_q || res_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ack_fire |=> (state_q == ST_CHECK))
    else $error("accepted ack did not enter CHECK");

  a_div_to_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_STEP) && stat_i.div_done |=> (state_q == ST_ALPHA))
    else $error("divide end did not lead to alpha update");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> res_valid_o)
    else $error("result load did not raise valid");

endmodule

`default_nettype wire

/* sv/dwe_datapath.sv */
// dwe_datapath: registers, mark history, serial divider and window scaler.
// Depends on dwe_pkg; driven by dwe_ctrl through dwe_cmd_t.
`default_nettype none

module dwe_datapath #(
  parameter int unsigned MAX_WINDOW = 256
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dwe_pkg::dwe_cmd_t    cmd_i,
  output dwe_pkg::dwe_stat_t        stat_o,
  input  wire dwe_pkg::ack_beat_t   ack_data_i,
  input  wire logic                 cfg_we_i,
  input  wire dwe_pkg::cfg_beat_t   cfg_data_i,
  output dwe_pkg::result_beat_t     res_data_o
);

  // The window is a 9-bit value clamped to MAX_WINDOW, so no more than
  // min(MAX_WINDOW, 511) history entries can ever be counted.
  localparam int unsigned HIST_MAX = (MAX_WINDOW < 511) ? MAX_WINDOW : 511;
  localparam int unsigned NCHUNK   = (HIST_MAX + dwe_pkg::CHUNK_W - 1) / dwe_pkg::CHUNK_W;
  localparam int unsigned CIDX_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int unsigned WIN_RST  = (MAX_WINDOW < dwe_pkg::INITIAL_WINDOW_RST) ?
                                     MAX_WINDOW : dwe_pkg::INITIAL_WINDOW_RST;

  function automatic logic [8:0] clamp_win(input logic [8:0] w);
    logic [8:0] r;
    if (w == 9'd0) begin
      r = 9'd1;
    end else if (13'(w) > 13'(MAX_WINDOW)) begin
      r = 9'(MAX_WINDOW);
    end else begin
      r = w;
    end
    return r;
  endfunction

  // configuration
  logic [31:0] flow_q;
  logic [15:0] seg_q;
  logic [3:0]  gain_q;

  // flow state
  logic [31:0] highest_q, send_q;
  logic        done_q;
  logic [15:0] hist_q [NCHUNK];
  logic [16:0] alpha_q;
  logic [8:0]  window_q;

  // per-ack work registers
  logic              new_ack_q, fin_q;
  logic [23:0]       sack_q;
  logic [CIDX_W-1:0] chunk_q;
  logic [8:0]        marks_q;
  logic [8:0]        rem_q;
  logic [16:0]       frac_q;
  logic [3:0]        step_q;
  logic [26:0]       prod_q;
  dwe_pkg::result_beat_t res_q;

  // capture
  logic        is_new;
  logic [24:0] sack_full;
  assign is_new    = ack_data_i.ack_seq > highest_q;
  assign sack_full = {16'd0, ack_data_i.sack_blocks} * {9'd0, seg_q};

  // mark count over one chunk
  logic [15:0] chunk_sel, chunk_mask;
  logic [8:0]  chunk_base, chunk_avail;
  logic [4:0]  last_chunk;
  assign chunk_sel   = hist_q[chunk_q];
  assign chunk_base  = 9'({chunk_q, 4'b0000});
  assign chunk_avail = window_q - chunk_base;
  assign last_chunk  = 5'((window_q - 9'd1) >> 4);

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      chunk_mask[j] = 9'(j) < chunk_avail;
    end
  end

  // divider step
  logic       q0;
  logic [9:0] rem_dbl;
  logic       qbit;
  assign q0      = marks_q >= window_q;
  assign rem_dbl = {rem_q, 1'b0};
  assign qbit    = rem_dbl >= {1'b0, window_q};

  // alpha update: flooring shift of the signed difference
  logic signed [17:0] alpha_diff, alpha_sh, alpha_sum;
  assign alpha_diff = $signed({1'b0, frac_q}) - $signed({1'b0, alpha_q});
  assign alpha_sh   = alpha_diff >>> gain_q;
  assign alpha_sum  = $signed({1'b0, alpha_q}) + alpha_sh;

  // window scale factor 2 - alpha
  logic [17:0] scale_fac;
  assign scale_fac = dwe_pkg::ALPHA_TWO - {1'b0, alpha_q};

  assign stat_o.is_new     = new_ack_q;
  assign stat_o.count_done = (5'(chunk_q) == last_chunk);
  assign stat_o.div_done   = (step_q == 4'd15);
  assign res_data_o        = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_q    <= dwe_pkg::FLOW_BYTES_RST;
      seg_q     <= dwe_pkg::SEGMENT_BYTES_RST;
      gain_q    <= dwe_pkg::GAIN_SHIFT_RST;
      highest_q <= '0;
      send_q    <= '0;
      done_q    <= 1'b0;
      alpha_q   <= '0;
      window_q  <= 9'(WIN_RST);
      new_ack_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (dwe_pkg::cfg_reg_e'(cfg_data_i.index))
          dwe_pkg::CFG_FLOW_BYTES:     flow_q <= cfg_data_i.value;
          dwe_pkg::CFG_SEGMENT_BYTES:  seg_q  <= cfg_data_i.value[15:0];
          dwe_pkg::CFG_GAIN_SHIFT:     gain_q <= cfg_data_i.value[3:0];
          dwe_pkg::CFG_INITIAL_WINDOW: window_q <= clamp_win(cfg_data_i.value[8:0]);
          default: ;
        endcase
      end
      if (cmd_i.capture) begin
        new_ack_q <= is_new;
        if (send_q < ack_data_i.ack_seq) begin
          send_q <= ack_data_i.ack_seq;
        end
        if (is_new) begin
          highest_q <= ack_data_i.ack_seq;
        end
        if ((ack_data_i.ack_seq == flow_q) && !done_q) begin
          done_q <= 1'b1;
        end
      end
      if (cmd_i.alpha_upd) begin
        alpha_q <= alpha_sum[16:0];
      end
      if (cmd_i.win_upd) begin
        window_q <= clamp_win(9'(prod_q >> 17));
      end
    end
  end

  // mark history: entry 0 newest, chunk c bit j is entry 16*c+j
  for (genvar c = 0; c < NCHUNK; c++) begin : g_hist
    logic shift_in;
    if (c == 0) begin : g_head
      assign shift_in = ack_data_i.ecn_echo;
    end else begin : g_link
      assign shift_in = hist_q[c-1][15];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hist_q[c] <= '0;
      end else if (cmd_i.capture && is_new) begin
        hist_q[c] <= {hist_q[c][14:0], shift_in};
      end
    end
  end

  // work registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      fin_q   <= (ack_data_i.ack_seq == flow_q) && !done_q;
      sack_q  <= sack_full[24] ? dwe_pkg::SACK_MAX : sack_full[23:0];
      chunk_q <= '0;
      marks_q <= '0;
    end
    if (cmd_i.count_step) begin
      marks_q <= marks_q + 9'($countones(chunk_sel & chunk_mask));
      chunk_q <= chunk_q + CIDX_W'(1);
    end
    if (cmd_i.div_init) begin
      rem_q  <= q0 ? (marks_q - window_q) : marks_q;
      frac_q <= {16'd0, q0};
      step_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= qbit ? 9'(rem_dbl - {1'b0, window_q}) : rem_dbl[8:0];
      frac_q <= {frac_q[15:0], qbit};
      step_q <= step_q + 4'd1;
    end
    if (cmd_i.mul_run) begin
      prod_q <= ({18'd0, window_q} * {9'd0, scale_fac}) + 27'(dwe_pkg::ALPHA_ONE);
    end
    if (cmd_i.out_load) begin
      res_q.new_ack       <= new_ack_q;
      res_q.window_out    <= window_q;
      res_q.alpha_out     <= alpha_q;
      res_q.send_seq_out  <= send_q;
      res_q.sack_bytes    <= sack_q;
      res_q.flow_finished <= fin_q;
    end
  end

  a_window_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (window_q != 9'd0) && (13'(window_q) <= 13'(MAX_WINDOW)))
    else $error("window out of range");

  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alpha_q <= dwe_pkg::ALPHA_ONE)
    else $error("alpha above one");

  a_window_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.win_upd |=> (window_q <= $past(window_q)))
    else $error("window grew on scaling");

endmodule

`default_nettype wire

/* dv/tb_dctcp_window_estimator_unit.sv */
`timescale 1ns / 100ps
// tb_dctcp_window_estimator_unit: self-checking bench for the DCTCP window estimator.
// Needs dwe_pkg, dwe_stream_if and dctcp_window_estimator_unit from the RTL; stand-alone otherwise.
// A shadow model of the estimator predicts each result beat; random acks and register phases drive it.

module tb_dctcp_window_estimator_unit;

  // History depth drives the shadow model and the DUT parameter alike
  localparam int unsigned WIN_MAX = 256;
  localparam logic [3:0] CFG_IDX_UNUSED = 4'hF;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_PERIODIC} rx_mode_e;

  logic clk;
  logic rst_n;

  dwe_stream_if #(.T(dwe_pkg::ack_beat_t))    ack_if ();
  dwe_stream_if #(.T(dwe_pkg::result_beat_t)) res_if ();
  dwe_stream_if #(.T(dwe_pkg::cfg_beat_t))    cfg_if ();

  dctcp_window_estimator_unit #(
    .MAX_WINDOW(WIN_MAX)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .ack_i (ack_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  // --------------------------------------------------------------------------
  // Shadow model of the estimator state and its registers
  // --------------------------------------------------------------------------
  logic [31:0]        sh_flow_bytes;
  logic [15:0]        sh_seg_bytes;
  logic [3:0]         sh_gain;
  logic [31:0]        sh_highest_ack;
  logic [31:0]        sh_next_send;
  logic [WIN_MAX-1:0] sh_marks;      // bit 0 holds the newest ECN echo
  int unsigned        sh_alpha;      // Q0.16, 65536 is 1.0
  int unsigned        sh_window;
  bit                 sh_flow_done;

  function automatic int unsigned clamp_window(longint unsigned w);
    if (w < 1) return 1;
    if (w > WIN_MAX) return WIN_MAX;
    return 32'(w);
  endfunction

  function automatic void apply_reg_write(dwe_pkg::cfg_beat_t c);
    case (c.index)
      dwe_pkg::CFG_FLOW_BYTES:     sh_flow_bytes = c.value;
      dwe_pkg::CFG_SEGMENT_BYTES:  sh_seg_bytes  = c.value[15:0];
      dwe_pkg::CFG_GAIN_SHIFT:     sh_gain       = c.value[3:0];
      dwe_pkg::CFG_INITIAL_WINDOW: sh_window     = clamp_window(64'(c.value[8:0]));
      default: ;
    endcase
  endfunction

  // One ack in, the result beat it should produce out; updates the shadow state.
  function automatic dwe_pkg::result_beat_t dctcp_step(dwe_pkg::ack_beat_t b);
    dwe_pkg::result_beat_t r;
    longint unsigned sack;
    longint unsigned scaled;
    int unsigned     marks;
    int unsigned     frac;
    int unsigned     diff;
    int unsigned     i;
    r    = '0;
    sack = longint'(b.sack_blocks) * longint'(sh_seg_bytes);
    if (sack > longint'(dwe_pkg::SACK_MAX)) sack = longint'(dwe_pkg::SACK_MAX);
    if (sh_next_send < b.ack_seq) sh_next_send = b.ack_seq;
    if (b.ack_seq > sh_highest_ack) begin
      r.new_ack      = 1'b1;
      sh_highest_ack = b.ack_seq;
      sh_marks       = {sh_marks[WIN_MAX-2:0], b.ecn_echo};
      marks = 0;
      for (i = 0; i < WIN_MAX; i++) begin
        if (i < sh_window) marks += sh_marks[i];
      end
      frac = (marks * 65536) / sh_window;
      // flooring shift of a signed difference: round down when alpha rises, up when it falls
      if (frac >= sh_alpha) begin
        sh_alpha += (frac - sh_alpha) >> sh_gain;
      end else begin
        diff = sh_alpha - frac;
        sh_alpha -= (diff + (1 << sh_gain) - 1) >> sh_gain;
      end
      scaled = (longint'(sh_window) * (longint'(dwe_pkg::ALPHA_TWO) - longint'(sh_alpha))
                + longint'(dwe_pkg::ALPHA_ONE)) >> 17;
      sh_window = clamp_window(scaled);
    end
    if (b.ack_seq == sh_flow_bytes && !sh_flow_done) begin
      sh_flow_done    = 1'b1;
      r.flow_finished = 1'b1;
    end
    r.window_out   = sh_window[8:0];
    r.alpha_out    = sh_alpha[16:0];
    r.send_seq_out = sh_next_send;
    r.sack_bytes   = sack[23:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Queues, counters and handshake bookkeeping
  // --------------------------------------------------------------------------
  dwe_pkg::ack_beat_t    ack_pending_q[$];   // acks waiting to be offered
  dwe_pkg::result_beat_t res_expect_q[$];    // predicted result beats, oldest first

  bit          ack_taken;           // set at the edge that accepts the offered beat
  bit          hold_req;            // asks the receiver for one long hold-off
  int unsigned err_cnt;
  int unsigned n_acks, n_new, n_sat, n_finish, n_cfg, n_results;
  int unsigned min_win;

  // --------------------------------------------------------------------------
  // Clock, reset, timeout
  // --------------------------------------------------------------------------
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Ack driver: bursts of random length, random gaps between them
  // --------------------------------------------------------------------------
  int unsigned tx_burst, tx_gap;

  always @(negedge clk) begin
    if (ack_if.valid && !ack_taken) begin
      // beat still on offer, hold it
    end else begin
      ack_taken = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        ack_if.valid <= 1'b0;
      end else if (ack_pending_q.size() > 0) begin
        ack_if.valid <= 1'b1;
        ack_if.data  <= ack_pending_q.pop_front();
        if (tx_burst > 0) begin
          tx_burst--;
        end else begin
          tx_burst = $urandom_range(0, 12);
          // about a third of the bursts run straight into the next one
          tx_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
        end
      end else begin
        ack_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: its own stall pattern plus one long hold-off on request
  // --------------------------------------------------------------------------
  rx_mode_e    rx_mode;
  int unsigned rx_tick, hold_left;

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:   res_if.ready <= 1'b1;
        RX_COIN:     res_if.ready <= ($urandom_range(0, 99) < 55);
        default:     res_if.ready <= ((rx_tick % 11) < 6);
      endcase
      rx_tick++;
      if (rx_tick % 256 == 0) rx_mode = rx_mode_e'($urandom_range(0, 2));
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on each accepted ack, checks each accepted result beat
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    dwe_pkg::result_beat_t exp_r;
    dwe_pkg::result_beat_t got_r;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        apply_reg_write(cfg_if.data);
        n_cfg++;
      end
      if (ack_if.valid && ack_if.ready) begin
        exp_r = dctcp_step(ack_if.data);
        res_expect_q.insert(res_expect_q.size(), exp_r);
        ack_taken = 1'b1;
        n_acks++;
        if (exp_r.new_ack) n_new++;
        if (exp_r.sack_bytes == dwe_pkg::SACK_MAX) n_sat++;
        if (exp_r.flow_finished) n_finish++;
        if (exp_r.window_out < min_win) min_win = exp_r.window_out;
      end
      if (res_if.valid && res_if.ready) begin
        got_r = res_if.data;
        n_results++;
        if (res_expect_q.size() == 0) begin
          $error("result beat with no ack waiting for it");
          err_cnt++;
        end else begin
          exp_r = res_expect_q.pop_front();
          if (got_r.new_ack !== exp_r.new_ack) begin
            $error("new_ack: expected %0d, got %0d", exp_r.new_ack, got_r.new_ack);
            err_cnt++;
          end
          if (got_r.window_out !== exp_r.window_out) begin
            $error("window_out: expected %0d, got %0d", exp_r.window_out, got_r.window_out);
            err_cnt++;
          end
          if (got_r.alpha_out !== exp_r.alpha_out) begin
            $error("alpha_out: expected %0d, got %0d", exp_r.alpha_out, got_r.alpha_out);
            err_cnt++;
          end
          if (got_r.send_seq_out !== exp_r.send_seq_out) begin
            $error("send_seq_out: expected 0x%08h, got 0x%08h",
                   exp_r.send_seq_out, got_r.send_seq_out);
            err_cnt++;
          end
          if (got_r.sack_bytes !== exp_r.sack_bytes) begin
            $error("sack_bytes: expected %0d, got %0d", exp_r.sack_bytes, got_r.sack_bytes);
            err_cnt++;
          end
          if (got_r.flow_finished !== exp_r.flow_finished) begin
            $error("flow_finished: expected %0d, got %0d",
                   exp_r.flow_finished, got_r.flow_finished);
            err_cnt++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  logic [31:0] seq_top;   // highest ack handed to the queue so far

  task automatic push_ack(input logic [31:0] seq, input logic ecn, input logic [8:0] blocks);
    ack_pending_q.insert(ack_pending_q.size(),
                         dwe_pkg::ack_beat_t'{ack_seq: seq, ecn_echo: ecn, sack_blocks: blocks});
    if (seq > seq_top) seq_top = seq;
  endtask

  // Mostly in-order advancing acks, some duplicates and stale ones
  task automatic push_random_ack(input int unsigned ecn_pct);
    int unsigned     pick;
    longint unsigned inc;
    logic [31:0]     seq;
    logic [8:0]      blocks;
    pick   = $urandom_range(0, 99);
    blocks = ($urandom_range(0, 1) == 0) ? 9'($urandom_range(0, 8))
                                         : 9'($urandom_range(0, 511));
    if (pick < 80) begin
      inc = ($urandom_range(0, 32) == 0) ? 64'($urandom_range(32'h1_0000, 32'h200_0000))
                                         : 64'($urandom_range(1, 3000));
      if (longint'(seq_top) + inc > 64'hFFFF_0000) inc = 1;
      seq = seq_top + inc[31:0];
    end else if (pick < 90) begin
      seq = seq_top;
    end else begin
      seq = $urandom_range(0, seq_top);
    end
    push_ack(seq, ($urandom_range(0, 99) < ecn_pct), blocks);
  endtask

  task automatic cfg_write(input logic [3:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= dwe_pkg::cfg_beat_t'{index: idx, value: val};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Block is idle once every ack went in and every result came out
  task automatic wait_idle();
    while (ack_pending_q.size() != 0 || ack_if.valid || res_expect_q.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned ph;
    int unsigned ecn_pct;
    int unsigned iw;
    clk           = 1'b0;
    rst_n         = 1'b0;
    ack_if.valid  = 1'b0;
    ack_if.data   = '0;
    res_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    ack_taken     = 1'b0;
    hold_req      = 1'b0;
    tx_burst      = 0;
    tx_gap        = 0;
    rx_mode       = RX_ALWAYS;
    rx_tick       = 0;
    hold_left     = 0;
    err_cnt       = 0;
    n_acks        = 0;
    n_new         = 0;
    n_sat         = 0;
    n_finish      = 0;
    n_cfg         = 0;
    n_results     = 0;
    min_win       = WIN_MAX;
    seq_top       = '0;

    sh_flow_bytes  = dwe_pkg::FLOW_BYTES_RST;
    sh_seg_bytes   = dwe_pkg::SEGMENT_BYTES_RST;
    sh_gain        = dwe_pkg::GAIN_SHIFT_RST;
    sh_highest_ack = '0;
    sh_next_send   = '0;
    sh_marks       = '0;
    sh_alpha       = 0;
    sh_window      = clamp_window(64'(dwe_pkg::INITIAL_WINDOW_RST));
    sh_flow_done   = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset register values. Ack 0 matches the default flow size and
    // finishes the flow; everything after runs with the flow already done.
    push_ack(32'd0,    1'b0, 9'd0);
    push_ack(32'd0,    1'b1, 9'd511);   // repeat of the finishing ack
    push_ack(32'd1460, 1'b1, 9'd1);
    push_ack(32'd1460, 1'b0, 9'd0);     // duplicate: no history shift
    push_ack(32'd100,  1'b1, 9'd3);     // stale ack
    push_ack(32'd2920, 1'b1, 9'd256);
    push_ack(32'd4380, 1'b0, 9'd7);
    wait_idle();

    // Unit gain, window of one (initial window 0 clamps up), largest segment
    cfg_write(dwe_pkg::CFG_FLOW_BYTES, 32'hFFFF_FFFF);
    cfg_write(dwe_pkg::CFG_SEGMENT_BYTES, 32'd65535);
    cfg_write(dwe_pkg::CFG_GAIN_SHIFT, 32'd0);
    cfg_write(dwe_pkg::CFG_INITIAL_WINDOW, 32'd0);
    cfg_write(CFG_IDX_UNUSED, 32'hFFFF_FFFF);   // must be ignored
    push_ack(32'd5000, 1'b1, 9'd511);   // SACK product saturates, alpha to 1.0
    push_ack(32'd6000, 1'b0, 9'd256);   // largest product that still fits
    push_ack(32'd7000, 1'b1, 9'd257);   // just past the ceiling
    wait_idle();

    // Oversized initial window clamps to the history depth, slowest gain
    cfg_write(dwe_pkg::CFG_INITIAL_WINDOW, 32'd511);
    cfg_write(dwe_pkg::CFG_GAIN_SHIFT, 32'd15);
    cfg_write(dwe_pkg::CFG_SEGMENT_BYTES, 32'd0);
    cfg_write(dwe_pkg::CFG_FLOW_BYTES, 32'd12345);
    push_ack(32'd8000, 1'b1, 9'd511);
    push_ack(32'd8500, 1'b1, 9'd100);
    push_ack(32'd9000, 1'b0, 9'd511);
    wait_idle();

    // Full window with a fast gain: history counted over every chunk
    cfg_write(dwe_pkg::CFG_INITIAL_WINDOW, 32'd256);
    cfg_write(dwe_pkg::CFG_GAIN_SHIFT, 32'd1);
    cfg_write(dwe_pkg::CFG_SEGMENT_BYTES, 32'd1);
    push_ack(32'd10000, 1'b1, 9'd2);
    push_ack(32'd11000, 1'b1, 9'd511);
    push_ack(32'd12000, 1'b0, 9'd0);

    // Random phases, each with fresh register values
    for (ph = 0; ph < 10; ph++) begin
      wait_idle();
      iw = $urandom_range(0, 9);
      if (iw < 5)      iw = $urandom_range(1, 32);
      else if (iw < 8) iw = $urandom_range(0, 511);
      else             iw = WIN_MAX;
      cfg_write(dwe_pkg::CFG_FLOW_BYTES, $urandom());
      cfg_write(dwe_pkg::CFG_SEGMENT_BYTES, ($urandom_range(0, 2) == 0) ? 32'd1460
                                                            : $urandom_range(0, 65535));
      cfg_write(dwe_pkg::CFG_GAIN_SHIFT, $urandom_range(0, 15));
      cfg_write(dwe_pkg::CFG_INITIAL_WINDOW, iw);
      case ($urandom_range(0, 4))
        0:       ecn_pct = 0;
        1:       ecn_pct = 5;
        2:       ecn_pct = 30;
        3:       ecn_pct = 70;
        default: ecn_pct = 100;
      endcase
      // late phases run in the upper half of the sequence space
      if (ph == 8 && seq_top < 32'h9000_0000)
        push_ack(32'h9000_0000 + $urandom_range(0, 32'hFFFF), 1'b1, 9'd0);
      // receiver backs off for a long stretch while acks keep coming
      if (ph == 3) hold_req = 1'b1;
      repeat (140) push_random_ack(ecn_pct);
    end

    // Top of the sequence space, then its duplicate
    push_ack(32'hFFFF_FFFF, 1'b1, 9'd511);
    push_ack(32'hFFFF_FFFF, 1'b0, 9'd1);

    wait_idle();
    repeat (50) @(posedge clk);

    $display("Run: %0d acks (%0d advancing), %0d result beats, %0d register writes.",
             n_acks, n_new, n_results, n_cfg);
    $display("Saturated SACK products: %0d, flow completions: %0d, narrowest window: %0d.",
             n_sat, n_finish, min_win);
    if (err_cnt == 0 && res_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
